// File: hw/rtl/cor_pkg.sv
`timescale 1ns / 1ps

package cor_pkg;

    typedef enum logic {
        OP_START = 1'b0,
        OP_STEP  = 1'b1
    } t_opcode;

    localparam int CANVAS_BITS = 13;
    localparam logic [CANVAS_BITS-1:0] CANVAS_RESET = 13'd800;

    localparam int COLOR_BITS = 24;

    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;

    typedef enum logic {
        REG_CANVAS_WIDTH  = 1'b0,
        REG_CANVAS_HEIGHT = 1'b1
    } t_reg_index;

    // 0.70710678 as the exact fraction SQRT_HALF_NUM / SQRT_HALF_DEN
    localparam int FRAC_BITS = 27;
    localparam logic [FRAC_BITS-1:0] SQRT_HALF_NUM = 27'd70710678;
    localparam logic [FRAC_BITS-1:0] SQRT_HALF_DEN = 27'd100000000;

    localparam int PIX_PER_STEP = 8;
    localparam int PIX_IDX_BITS = 3;

endpackage

// File: hw/rtl/cor_cfg.sv
`timescale 1ns / 1ps

module cor_cfg
    import cor_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready,
    output logic [CANVAS_BITS-1:0]   o_canvas_w,
    output logic [CANVAS_BITS-1:0]   o_canvas_h
);

    logic [CANVAS_BITS-1:0] r_canvas_w;
    logic [CANVAS_BITS-1:0] r_canvas_h;
    logic                   wr_en;
    t_reg_index             reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = t_reg_index'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_canvas_w <= CANVAS_RESET;
            r_canvas_h <= CANVAS_RESET;
        end else if (wr_en) begin
            case (reg_idx)
                REG_CANVAS_WIDTH:  r_canvas_w <= pwdata[CANVAS_BITS-1:0];
                REG_CANVAS_HEIGHT: r_canvas_h <= pwdata[CANVAS_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_CANVAS_WIDTH:  prdata = APB_DATA_BITS'(r_canvas_w);
            REG_CANVAS_HEIGHT: prdata = APB_DATA_BITS'(r_canvas_h);
            default:           prdata = '0;
        endcase
    end

    assign o_canvas_w = r_canvas_w;
    assign o_canvas_h = r_canvas_h;

endmodule

// File: hw/rtl/cor_core.sv
`timescale 1ns / 1ps

module cor_core
    import cor_pkg::*;
#(
    parameter int COORD_BITS  = 12,
    parameter int RADIUS_BITS = 10
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  t_opcode                       i_op,
    input  logic [COORD_BITS-1:0]         i_cx,
    input  logic [COORD_BITS-1:0]         i_cy,
    input  logic [RADIUS_BITS-1:0]        i_radius,
    input  logic [COLOR_BITS-1:0]         i_color,
    output logic                          o_load_valid,
    input  logic                          i_load_ready,
    output logic [COORD_BITS-1:0]         o_cx,
    output logic [COORD_BITS-1:0]         o_cy,
    output logic [RADIUS_BITS-1:0]        o_x,
    output logic signed [RADIUS_BITS+1:0] o_y,
    output logic [COLOR_BITS-1:0]         o_color,
    output logic                          o_done
);

    localparam int Y_W    = RADIUS_BITS + 2;
    localparam int DIFF_W = 2 * RADIUS_BITS + 3;
    localparam int PROD_W = RADIUS_BITS + FRAC_BITS;

    // input register
    logic                   r_in_valid;
    t_opcode                r_op;
    logic [COORD_BITS-1:0]  r_in_cx;
    logic [COORD_BITS-1:0]  r_in_cy;
    logic [RADIUS_BITS-1:0] r_in_rad;
    logic [COLOR_BITS-1:0]  r_in_color;

    // circle state
    logic                     r_active;
    logic [COORD_BITS-1:0]    r_cx;
    logic [COORD_BITS-1:0]    r_cy;
    logic [COLOR_BITS-1:0]    r_color;
    logic [RADIUS_BITS-1:0]   r_x;
    logic signed [Y_W-1:0]    r_y;
    logic signed [Y_W-1:0]    r_term;
    logic signed [DIFF_W-1:0] r_diff;
    logic [PROD_W-1:0]        r_prod;
    logic [PROD_W-1:0]        r_acc;

    logic                     n_active;
    logic [RADIUS_BITS-1:0]   n_x;
    logic signed [Y_W-1:0]    n_y;
    logic signed [Y_W-1:0]    n_term;
    logic signed [DIFF_W-1:0] n_diff;
    logic [PROD_W-1:0]        n_prod;
    logic [PROD_W-1:0]        n_acc;

    logic                     is_start;
    logic                     consume;
    logic                     step_go;
    logic                     dec;
    logic                     done;
    logic signed [Y_W-1:0]    y_step;
    logic signed [DIFF_W-1:0] diff_mid;
    logic signed [DIFF_W-1:0] col_inc;

    assign is_start     = (r_op == OP_START);
    assign o_load_valid = r_in_valid && !is_start && r_active;
    assign step_go      = o_load_valid && i_load_ready;
    assign consume      = r_in_valid && (is_start || !r_active || i_load_ready);
    assign o_ready      = !r_in_valid || consume;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_op       <= i_op;
            r_in_cx    <= i_cx;
            r_in_cy    <= i_cy;
            r_in_rad   <= i_radius;
            r_in_color <= i_color;
        end
    end

    // one column of the midpoint walk
    assign dec      = r_diff >= DIFF_W'(r_term);
    assign y_step   = dec ? r_y - Y_W'(1) : r_y;
    assign diff_mid = dec ? r_diff - DIFF_W'(r_term) : r_diff;
    assign col_inc  = DIFF_W'($signed({1'b0, r_x, 1'b0})) - DIFF_W'(3);
    assign done     = r_acc > r_prod;

    always_comb begin
        n_active = r_active;
        n_x      = r_x;
        n_y      = r_y;
        n_term   = r_term;
        n_diff   = r_diff;
        n_prod   = r_prod;
        n_acc    = r_acc;
        if (r_in_valid && is_start) begin
            n_active = 1'b1;
            n_x      = '0;
            n_y      = $signed(Y_W'(r_in_rad));
            n_term   = $signed(Y_W'({r_in_rad, 1'b0})) - Y_W'(1);
            n_diff   = '0;
            n_prod   = PROD_W'(r_in_rad) * PROD_W'(SQRT_HALF_NUM);
            n_acc    = PROD_W'(SQRT_HALF_DEN);
        end else if (step_go) begin
            n_active = !done;
            n_x      = r_x + RADIUS_BITS'(1);
            n_y      = y_step;
            n_term   = dec ? r_term - Y_W'(2) : r_term;
            n_diff   = diff_mid + col_inc;
            n_acc    = r_acc + PROD_W'(SQRT_HALF_DEN);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else begin
            r_active <= n_active;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x    <= n_x;
        r_y    <= n_y;
        r_term <= n_term;
        r_diff <= n_diff;
        r_prod <= n_prod;
        r_acc  <= n_acc;
        if (r_in_valid && is_start) begin
            r_cx    <= r_in_cx;
            r_cy    <= r_in_cy;
            r_color <= r_in_color;
        end
    end

    assign o_cx    = r_cx;
    assign o_cy    = r_cy;
    assign o_x     = r_x;
    assign o_y     = y_step;
    assign o_color = r_color;
    assign o_done  = done;

endmodule

// File: hw/rtl/cor_emit.sv
`timescale 1ns / 1ps

module cor_emit
    import cor_pkg::*;
#(
    parameter int COORD_BITS  = 12,
    parameter int RADIUS_BITS = 10
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load_valid,
    output logic                          o_load_ready,
    input  logic [COORD_BITS-1:0]         i_cx,
    input  logic [COORD_BITS-1:0]         i_cy,
    input  logic [RADIUS_BITS-1:0]        i_x,
    input  logic signed [RADIUS_BITS+1:0] i_y,
    input  logic [COLOR_BITS-1:0]         i_color,
    input  logic                          i_done,
    input  logic [CANVAS_BITS-1:0]        i_canvas_w,
    input  logic [CANVAS_BITS-1:0]        i_canvas_h,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [COORD_BITS+1:0]         o_px,
    output logic [COORD_BITS+1:0]         o_py,
    output logic [COLOR_BITS-1:0]         o_color,
    output logic                          o_in_bounds,
    output logic                          o_last,
    output logic                          o_circle_done
);

    localparam int PIX_BITS = COORD_BITS + 2;
    localparam int Y_W      = RADIUS_BITS + 2;
    localparam int MAX_A    = (COORD_BITS > Y_W) ? COORD_BITS : Y_W;
    localparam int MAX_B    = (MAX_A > CANVAS_BITS) ? MAX_A : CANVAS_BITS;
    localparam int SUM_W    = MAX_B + 2;
    localparam logic [PIX_IDX_BITS-1:0] LAST_IDX = PIX_IDX_BITS'(PIX_PER_STEP - 1);

    // base of the column being sent
    logic                    r_pend;
    logic [PIX_IDX_BITS-1:0] r_cnt;
    logic [COORD_BITS-1:0]   r_cx;
    logic [COORD_BITS-1:0]   r_cy;
    logic [RADIUS_BITS-1:0]  r_x;
    logic signed [Y_W-1:0]   r_y;
    logic [COLOR_BITS-1:0]   r_color;
    logic                    r_done;

    // output register
    logic                  r_out_valid;
    logic [PIX_BITS-1:0]   r_px;
    logic [PIX_BITS-1:0]   r_py;
    logic [COLOR_BITS-1:0] r_out_color;
    logic                  r_in_bounds;
    logic                  r_last;
    logic                  r_circle_done;

    logic                    out_adv;
    logic                    produce;
    logic                    at_last;
    logic                    load;
    logic signed [SUM_W-1:0] ext_x;
    logic signed [SUM_W-1:0] ext_y;
    logic signed [SUM_W-1:0] off_a;
    logic signed [SUM_W-1:0] off_b;
    logic signed [SUM_W-1:0] px;
    logic signed [SUM_W-1:0] py;
    logic                    px_in;
    logic                    py_in;

    assign out_adv      = !r_out_valid || i_ready;
    assign produce      = r_pend && out_adv;
    assign at_last      = (r_cnt == LAST_IDX);
    assign o_load_ready = !r_pend || (produce && at_last);
    assign load         = i_load_valid && o_load_ready;

    // octant mirror selected by the pixel index
    assign ext_x = SUM_W'($signed({1'b0, r_x}));
    assign ext_y = SUM_W'(r_y);
    assign off_a = r_cnt[2] ? ext_y : ext_x;
    assign off_b = r_cnt[2] ? ext_x : ext_y;
    assign px = SUM_W'($signed({1'b0, r_cx})) + (r_cnt[1] ? -off_a : off_a);
    assign py = SUM_W'($signed({1'b0, r_cy})) + (r_cnt[0] ? -off_b : off_b);
    assign px_in = !px[SUM_W-1] && (px < SUM_W'($signed({1'b0, i_canvas_w})));
    assign py_in = !py[SUM_W-1] && (py < SUM_W'($signed({1'b0, i_canvas_h})));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_pend <= 1'b1;
                r_cnt  <= '0;
            end else if (produce) begin
                r_pend <= !at_last;
                r_cnt  <= r_cnt + PIX_IDX_BITS'(1);
            end
            if (produce) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cx    <= i_cx;
            r_cy    <= i_cy;
            r_x     <= i_x;
            r_y     <= i_y;
            r_color <= i_color;
            r_done  <= i_done;
        end
        if (produce) begin
            r_px          <= px[PIX_BITS-1:0];
            r_py          <= py[PIX_BITS-1:0];
            r_out_color   <= r_color;
            r_in_bounds   <= px_in && py_in;
            r_last        <= at_last;
            r_circle_done <= at_last && r_done;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_px          = r_px;
    assign o_py          = r_py;
    assign o_color       = r_out_color;
    assign o_in_bounds   = r_in_bounds;
    assign o_last        = r_last;
    assign o_circle_done = r_circle_done;

endmodule

// File: hw/rtl/circle_outline_rasterizer.sv
`timescale 1ns / 1ps
// Circle outline rasterizer, midpoint walk with eight-way symmetry.
// Input stream: tuser is the opcode; start (0) loads center, radius and color
// and sends nothing, step (1) runs one column and sends its eight pixels.
// Output stream: one pixel per beat in octant order, tlast on the eighth,
// tuser flags in_bounds against the canvas and circle_done on the last pixel of the final column.
// A step with no circle in progress sends nothing.
// APB port: canvas_width at 0x0, canvas_height at 0x4, both 800 after reset;
// write them only while the block is idle.
// A step's first pixel passes the input register, the column base register and the
// output register; the output serializer sends one pixel per cycle while the receiver
// is ready, and a start overlaps a step still being sent.
// The input register accepts the next beat while pixels drain; when the
// receiver stalls, the output register holds its beat and the input side
// backs up once the input register holds a step waiting for the serializer.
// Reset (synchronous, active low) drops any circle in progress and any pixels
// not yet sent, and restores the canvas size.

module circle_outline_rasterizer
    import cor_pkg::*;
#(
    parameter int COORD_BITS  = 12,
    parameter int RADIUS_BITS = 10
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    // center_x, center_y, radius, draw_color, zero pad
    input  logic [((2*COORD_BITS+RADIUS_BITS+COLOR_BITS+7)/8)*8-1:0] s_axis_tdata,
    // opcode
    input  logic                     s_axis_tuser,
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // pixel_x, pixel_y, pixel_color, zero pad
    output logic [((2*(COORD_BITS+2)+COLOR_BITS+7)/8)*8-1:0] m_axis_tdata,
    // in_bounds, circle_done
    output logic [1:0]               m_axis_tuser,
    output logic                     m_axis_tlast,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready
);

    localparam int PIX_BITS  = COORD_BITS + 2;
    localparam int OUT_FLDS  = 2 * PIX_BITS + COLOR_BITS;
    localparam int OUT_W     = ((OUT_FLDS + 7) / 8) * 8;
    localparam int CY_LO     = COORD_BITS;
    localparam int RAD_LO    = 2 * COORD_BITS;
    localparam int COL_LO    = 2 * COORD_BITS + RADIUS_BITS;

    logic [CANVAS_BITS-1:0]        canvas_w;
    logic [CANVAS_BITS-1:0]        canvas_h;
    logic                          load_valid;
    logic                          load_ready;
    logic [COORD_BITS-1:0]         base_cx;
    logic [COORD_BITS-1:0]         base_cy;
    logic [RADIUS_BITS-1:0]        base_x;
    logic signed [RADIUS_BITS+1:0] base_y;
    logic [COLOR_BITS-1:0]         base_color;
    logic                          base_done;
    logic [PIX_BITS-1:0]           pix_x;
    logic [PIX_BITS-1:0]           pix_y;
    logic [COLOR_BITS-1:0]         pix_color;
    logic                          pix_in_bounds;
    logic                          pix_done;

    cor_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_canvas_w (canvas_w),
        .o_canvas_h (canvas_h)
    );

    cor_core #(
        .COORD_BITS  (COORD_BITS),
        .RADIUS_BITS (RADIUS_BITS)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_op         (t_opcode'(s_axis_tuser)),
        .i_cx         (s_axis_tdata[COORD_BITS-1:0]),
        .i_cy         (s_axis_tdata[CY_LO +: COORD_BITS]),
        .i_radius     (s_axis_tdata[RAD_LO +: RADIUS_BITS]),
        .i_color      (s_axis_tdata[COL_LO +: COLOR_BITS]),
        .o_load_valid (load_valid),
        .i_load_ready (load_ready),
        .o_cx         (base_cx),
        .o_cy         (base_cy),
        .o_x          (base_x),
        .o_y          (base_y),
        .o_color      (base_color),
        .o_done       (base_done)
    );

    cor_emit #(
        .COORD_BITS  (COORD_BITS),
        .RADIUS_BITS (RADIUS_BITS)
    ) u_emit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load_valid  (load_valid),
        .o_load_ready  (load_ready),
        .i_cx          (base_cx),
        .i_cy          (base_cy),
        .i_x           (base_x),
        .i_y           (base_y),
        .i_color       (base_color),
        .i_done        (base_done),
        .i_canvas_w    (canvas_w),
        .i_canvas_h    (canvas_h),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_px          (pix_x),
        .o_py          (pix_y),
        .o_color       (pix_color),
        .o_in_bounds   (pix_in_bounds),
        .o_last        (m_axis_tlast),
        .o_circle_done (pix_done)
    );

    assign m_axis_tdata = OUT_W'({pix_color, pix_y, pix_x});
    assign m_axis_tuser = {pix_done, pix_in_bounds};

endmodule
